@@ rtl/csl_pkg.sv @@
// csl_pkg: token kinds, character codes, keyword patterns and helpers of the lexer
package csl_pkg;

    // token kinds
    typedef logic [4:0] kind_t;

    localparam kind_t K_EOF     = 5'd0;
    localparam kind_t K_NUM     = 5'd1;
    localparam kind_t K_STR     = 5'd2;
    localparam kind_t K_IDENT   = 5'd3;
    localparam kind_t K_INT     = 5'd4;
    localparam kind_t K_IF      = 5'd5;
    localparam kind_t K_ELSE    = 5'd6;
    localparam kind_t K_WHILE   = 5'd7;
    localparam kind_t K_RETURN  = 5'd8;
    localparam kind_t K_EQ      = 5'd9;
    localparam kind_t K_NE      = 5'd10;
    localparam kind_t K_LE      = 5'd11;
    localparam kind_t K_GE      = 5'd12;
    localparam kind_t K_PLUS    = 5'd13;
    localparam kind_t K_MINUS   = 5'd14;
    localparam kind_t K_STAR    = 5'd15;
    localparam kind_t K_SLASH   = 5'd16;
    localparam kind_t K_PERCENT = 5'd17;
    localparam kind_t K_LT      = 5'd18;
    localparam kind_t K_GT      = 5'd19;
    localparam kind_t K_ASSIGN  = 5'd20;
    localparam kind_t K_NOT     = 5'd21;
    localparam kind_t K_AMP     = 5'd22;
    localparam kind_t K_LPAREN  = 5'd23;
    localparam kind_t K_RPAREN  = 5'd24;
    localparam kind_t K_LBRACE  = 5'd25;
    localparam kind_t K_RBRACE  = 5'd26;
    localparam kind_t K_LBRACK  = 5'd27;
    localparam kind_t K_RBRACK  = 5'd28;
    localparam kind_t K_SEMI    = 5'd29;
    localparam kind_t K_COMMA   = 5'd30;
    localparam kind_t K_ERR     = 5'd31;

    // ascii codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // widths and keyword patterns, last byte of the word in the low byte
    localparam int VALUE_BITS = 63;
    localparam int WIN_BITS   = 48;

    localparam logic [WIN_BITS-1:0] KW_INT    = 48'h0000_0069_6E74;
    localparam logic [WIN_BITS-1:0] KW_IF     = 48'h0000_0000_6966;
    localparam logic [WIN_BITS-1:0] KW_ELSE   = 48'h0000_656C_7365;
    localparam logic [WIN_BITS-1:0] KW_WHILE  = 48'h0077_6869_6C65;
    localparam logic [WIN_BITS-1:0] KW_RETURN = 48'h7265_7475_726E;

    // result queue
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;

    // scanner modes
    typedef enum logic [11:0] {
        M_IDLE       = 12'b0000_0000_0001,
        M_NUM        = 12'b0000_0000_0010,
        M_IDENT      = 12'b0000_0000_0100,
        M_STR        = 12'b0000_0000_1000,
        M_CHR_OPEN   = 12'b0000_0001_0000,
        M_CHR_ESC    = 12'b0000_0010_0000,
        M_CHR_VAL    = 12'b0000_0100_0000,
        M_OP         = 12'b0000_1000_0000,
        M_SLASH      = 12'b0001_0000_0000,
        M_LINE       = 12'b0010_0000_0000,
        M_BLOCK      = 12'b0100_0000_0000,
        M_BLOCK_STAR = 12'b1000_0000_0000
    } mode_t;

    // one token as it leaves the block
    typedef struct packed {
        kind_t                 kind;
        logic [VALUE_BITS-1:0] value;
        logic [31:0]           start;
        logic [15:0]           length;
        logic                  last;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // single-character punctuation; K_EOF means the byte is not punctuation
    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_PLUS:    k = K_PLUS;
            CH_MINUS:   k = K_MINUS;
            CH_STAR:    k = K_STAR;
            CH_SLASH:   k = K_SLASH;
            CH_PERCENT: k = K_PERCENT;
            CH_LT:      k = K_LT;
            CH_GT:      k = K_GT;
            CH_EQ:      k = K_ASSIGN;
            CH_BANG:    k = K_NOT;
            CH_AMP:     k = K_AMP;
            CH_LPAREN:  k = K_LPAREN;
            CH_RPAREN:  k = K_RPAREN;
            CH_LBRACE:  k = K_LBRACE;
            CH_RBRACE:  k = K_RBRACE;
            CH_LBRACK:  k = K_LBRACK;
            CH_RBRACK:  k = K_RBRACK;
            CH_SEMI:    k = K_SEMI;
            CH_COMMA:   k = K_COMMA;
            default:    k = K_EOF;
        endcase
        return k;
    endfunction

    // two-character operator from its first byte
    function automatic kind_t pair_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_EQ:   k = K_EQ;
            CH_BANG: k = K_NE;
            CH_LT:   k = K_LE;
            default: k = K_GE;
        endcase
        return k;
    endfunction

    // value of the byte after a backslash in a character literal
    function automatic logic [7:0] esc_value(input logic [7:0] c);
        logic [7:0] v;
        case (c)
            CH_LOWER_N: v = CH_NL;
            CH_LOWER_T: v = CH_TAB;
            CH_ZERO:    v = 8'h00;
            default:    v = c;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/c_subset_lexer.sv @@
// c_subset_lexer: streaming tokenizer for a small C subset, one source byte per beat
// Each token is written into the result queue on the input beat whose byte completes it.
// Throughput: one input beat per cycle while each byte yields at most one token and the
// output drains; a byte that yields two tokens takes two output beats, and the 4-entry
// result queue absorbs them, holding off input only when fewer than two entries are free.
// Reset: scanner goes idle, offset and all counters clear, the result queue empties.
module c_subset_lexer
    import csl_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  token_kind,
    output logic [62:0] token_value,
    output logic [31:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_run
);

    // scanner state
    mode_t                   mode_reg, mode_next;
    logic [VALUE_BITS-1:0]   accum_reg, accum_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [LENGTH_BITS-1:0]  len_reg, len_next;
    logic [WIN_BITS-1:0]     win_reg, win_next;
    logic                    esc_reg, esc_next;
    logic                    halt_reg, halt_next;

    // result queue
    result_t                 fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_BITS:0]  count_reg, count_next;

    logic                    in_fire, out_fire;
    logic [POSITION_BITS-1:0] pos_plus;
    logic [LENGTH_BITS-1:0]  len_plus;
    logic [VALUE_BITS+3:0]   num_wide;
    logic [VALUE_BITS-1:0]   num_sat;
    kind_t                   ident_kind;

    logic                    flush_valid;
    result_t                 flush_res;

    mode_t                   idle_mode;
    logic [VALUE_BITS-1:0]   idle_accum;
    logic [POSITION_BITS-1:0] idle_start;
    logic [LENGTH_BITS-1:0]  idle_len;
    logic [WIN_BITS-1:0]     idle_win;
    logic                    idle_emit, idle_halt;
    result_t                 idle_res;

    logic                    e0_valid, e1_valid, redo;
    result_t                 e0, e1, push0, push1;
    logic [1:0]              push_cnt;
    result_t                 head;

    // offset and length narrowed or widened to the port widths
    function automatic logic [31:0] to_start(input logic [POSITION_BITS-1:0] p);
        logic [POSITION_BITS+31:0] w;
        w = {32'b0, p};
        return w[31:0];
    endfunction

    function automatic logic [15:0] to_len(input logic [LENGTH_BITS-1:0] n);
        logic [LENGTH_BITS+15:0] w;
        w = {16'b0, n};
        return w[15:0];
    endfunction

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // counters
    assign pos_plus = pos_reg + POSITION_BITS'(1);
    assign len_plus = (&len_reg) ? len_reg : len_reg + LENGTH_BITS'(1);

    // decimal accumulate, saturating; low nibble of an ascii digit is its value
    assign num_wide = {1'b0, accum_reg, 3'b0} + {3'b0, accum_reg, 1'b0}
                    + {{VALUE_BITS{1'b0}}, ch[3:0]};
    assign num_sat  = (|num_wide[VALUE_BITS+3:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
                                                            : num_wide[VALUE_BITS-1:0];

    // keyword match on the last six bytes of an identifier
    always_comb
    begin
        priority if (len_reg == LENGTH_BITS'(3) && win_reg == KW_INT)
            ident_kind = K_INT;
        else if (len_reg == LENGTH_BITS'(2) && win_reg == KW_IF)
            ident_kind = K_IF;
        else if (len_reg == LENGTH_BITS'(4) && win_reg == KW_ELSE)
            ident_kind = K_ELSE;
        else if (len_reg == LENGTH_BITS'(5) && win_reg == KW_WHILE)
            ident_kind = K_WHILE;
        else if (len_reg == LENGTH_BITS'(6) && win_reg == KW_RETURN)
            ident_kind = K_RETURN;
        else
            ident_kind = K_IDENT;
    end

    // token held in the scanner, as it would be emitted now
    always_comb
    begin
        flush_valid      = 1'b1;
        flush_res.kind   = K_NUM;
        flush_res.value  = '0;
        flush_res.start  = to_start(start_reg);
        flush_res.length = to_len(len_reg);
        flush_res.last   = 1'b0;
        unique case (mode_reg)
            M_NUM, M_CHR_OPEN, M_CHR_ESC, M_CHR_VAL:
            begin
                flush_res.value = accum_reg;
            end
            M_IDENT:
            begin
                flush_res.kind = ident_kind;
            end
            M_STR:
            begin
                flush_res.kind = K_STR;
            end
            M_OP:
            begin
                flush_res.kind   = punct_kind(accum_reg[7:0]);
                flush_res.length = 16'd1;
            end
            M_SLASH:
            begin
                flush_res.kind   = K_SLASH;
                flush_res.length = 16'd1;
            end
            default:
            begin
                flush_valid = 1'b0;
            end
        endcase
    end

    // byte seen from the idle scanner
    always_comb
    begin
        idle_mode       = M_IDLE;
        idle_accum      = '0;
        idle_start      = start_reg;
        idle_len        = '0;
        idle_win        = '0;
        idle_emit       = 1'b0;
        idle_halt       = 1'b0;
        idle_res.kind   = K_ERR;
        idle_res.value  = '0;
        idle_res.start  = to_start(pos_reg);
        idle_res.length = 16'd1;
        idle_res.last   = 1'b0;
        priority if (is_space(ch))
        begin
            idle_mode = M_IDLE;
        end
        else if (is_digit(ch))
        begin
            idle_mode  = M_NUM;
            idle_accum = {{(VALUE_BITS-4){1'b0}}, ch[3:0]};
            idle_start = pos_reg;
            idle_len   = LENGTH_BITS'(1);
        end
        else if (is_alpha(ch))
        begin
            idle_mode  = M_IDENT;
            idle_win   = {{(WIN_BITS-8){1'b0}}, ch};
            idle_start = pos_reg;
            idle_len   = LENGTH_BITS'(1);
        end
        else if (ch == CH_DQUOTE)
        begin
            idle_mode  = M_STR;
            idle_start = pos_plus;
        end
        else if (ch == CH_SQUOTE)
        begin
            idle_mode  = M_CHR_OPEN;
            idle_start = pos_reg;
            idle_len   = LENGTH_BITS'(1);
        end
        else if (ch == CH_SLASH)
        begin
            idle_mode  = M_SLASH;
            idle_start = pos_reg;
        end
        else if (ch == CH_EQ || ch == CH_BANG || ch == CH_LT || ch == CH_GT)
        begin
            idle_mode  = M_OP;
            idle_accum = {{(VALUE_BITS-8){1'b0}}, ch};
            idle_start = pos_reg;
        end
        else if (punct_kind(ch) != K_EOF)
        begin
            idle_emit     = 1'b1;
            idle_res.kind = punct_kind(ch);
        end
        else
        begin
            // illegal byte stops the scanner until end of input
            idle_emit = 1'b1;
            idle_halt = 1'b1;
        end
    end

    // next scanner state and the up to two tokens of this beat
    always_comb
    begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        win_next   = win_reg;
        esc_next   = esc_reg;
        halt_next  = halt_reg;
        e0_valid   = 1'b0;
        e0         = flush_res;
        e1_valid   = 1'b0;
        e1         = idle_res;
        redo       = 1'b0;
        if (in_fire)
        begin
            if (end_of_input)
            begin
                // flush, report end of source, start over at offset zero
                e0_valid   = flush_valid && !halt_reg;
                e1_valid   = 1'b1;
                e1.kind    = K_EOF;
                e1.value   = '0;
                e1.start   = to_start(pos_reg);
                e1.length  = '0;
                e1.last    = 1'b0;
                mode_next  = M_IDLE;
                accum_next = '0;
                start_next = '0;
                pos_next   = '0;
                len_next   = '0;
                win_next   = '0;
                esc_next   = 1'b0;
                halt_next  = 1'b0;
            end
            else
            begin
                pos_next = pos_plus;
                if (!halt_reg)
                begin
                    unique case (mode_reg)
                        M_NUM:
                        begin
                            if (is_digit(ch))
                            begin
                                accum_next = num_sat;
                                len_next   = len_plus;
                            end
                            else
                                redo = 1'b1;
                        end
                        M_IDENT:
                        begin
                            if (is_alpha(ch) || is_digit(ch))
                            begin
                                win_next = {win_reg[WIN_BITS-9:0], ch};
                                len_next = len_plus;
                            end
                            else
                                redo = 1'b1;
                        end
                        M_STR:
                        begin
                            if (esc_reg)
                            begin
                                esc_next = 1'b0;
                                len_next = len_plus;
                            end
                            else if (ch == CH_BSLASH)
                            begin
                                esc_next = 1'b1;
                                len_next = len_plus;
                            end
                            else if (ch == CH_DQUOTE)
                            begin
                                e0_valid   = 1'b1;
                                mode_next  = M_IDLE;
                                accum_next = '0;
                                len_next   = '0;
                                win_next   = '0;
                                esc_next   = 1'b0;
                            end
                            else
                                len_next = len_plus;
                        end
                        M_CHR_OPEN:
                        begin
                            len_next = len_plus;
                            if (ch == CH_BSLASH)
                                mode_next = M_CHR_ESC;
                            else
                            begin
                                accum_next = {{(VALUE_BITS-8){1'b0}}, ch};
                                mode_next  = M_CHR_VAL;
                            end
                        end
                        M_CHR_ESC:
                        begin
                            len_next   = len_plus;
                            accum_next = {{(VALUE_BITS-8){1'b0}}, esc_value(ch)};
                            mode_next  = M_CHR_VAL;
                        end
                        M_CHR_VAL:
                        begin
                            if (ch == CH_SQUOTE)
                            begin
                                // closing quote counts toward the length
                                e0_valid   = 1'b1;
                                e0.length  = to_len(len_plus);
                                mode_next  = M_IDLE;
                                accum_next = '0;
                                len_next   = '0;
                                win_next   = '0;
                                esc_next   = 1'b0;
                            end
                            else
                                redo = 1'b1;
                        end
                        M_OP:
                        begin
                            if (ch == CH_EQ)
                            begin
                                e0_valid   = 1'b1;
                                e0.kind    = pair_kind(accum_reg[7:0]);
                                e0.length  = 16'd2;
                                mode_next  = M_IDLE;
                                accum_next = '0;
                                len_next   = '0;
                                win_next   = '0;
                                esc_next   = 1'b0;
                            end
                            else
                                redo = 1'b1;
                        end
                        M_SLASH:
                        begin
                            if (ch == CH_SLASH)
                                mode_next = M_LINE;
                            else if (ch == CH_STAR)
                                mode_next = M_BLOCK;
                            else
                                redo = 1'b1;
                        end
                        M_LINE:
                        begin
                            if (ch == CH_NL)
                            begin
                                mode_next  = M_IDLE;
                                accum_next = '0;
                                len_next   = '0;
                                win_next   = '0;
                                esc_next   = 1'b0;
                            end
                        end
                        M_BLOCK:
                        begin
                            if (ch == CH_STAR)
                                mode_next = M_BLOCK_STAR;
                        end
                        M_BLOCK_STAR:
                        begin
                            if (ch == CH_SLASH)
                            begin
                                mode_next  = M_IDLE;
                                accum_next = '0;
                                len_next   = '0;
                                win_next   = '0;
                                esc_next   = 1'b0;
                            end
                            else if (ch != CH_STAR)
                                mode_next = M_BLOCK;
                        end
                        default:
                        begin
                            redo = 1'b1;
                        end
                    endcase

                    // token ended by this byte: emit it, then lex the byte from idle
                    if (redo)
                    begin
                        e0_valid   = flush_valid;
                        mode_next  = idle_mode;
                        accum_next = idle_accum;
                        start_next = idle_start;
                        len_next   = idle_len;
                        win_next   = idle_win;
                        esc_next   = 1'b0;
                        halt_next  = idle_halt;
                        e1_valid   = idle_emit;
                    end
                end
            end
        end
    end

    // order the tokens and mark the last one of the beat
    always_comb
    begin
        push0 = e0;
        push1 = e1;
        push0.last = 1'b0;
        push1.last = 1'b1;
        priority if (e0_valid && e1_valid)
        begin
            push_cnt = 2'd2;
        end
        else if (e0_valid)
        begin
            push0.last = 1'b1;
            push_cnt   = 2'd1;
        end
        else if (e1_valid)
        begin
            push0      = e1;
            push0.last = 1'b1;
            push_cnt   = 2'd1;
        end
        else
        begin
            push_cnt = 2'd0;
        end
    end

    // scanner registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            accum_reg <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
            win_reg   <= '0;
            esc_reg   <= 1'b0;
            halt_reg  <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            accum_reg <= accum_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            win_reg   <= win_next;
            esc_reg   <= esc_next;
            halt_reg  <= halt_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            fifo_mem[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            fifo_mem[wr_ptr_reg + FIFO_PTR_BITS'(1)] <= push1;
    end

    // result queue pointers
    assign count_next = count_reg + (FIFO_PTR_BITS+1)'(push_cnt)
                      - (FIFO_PTR_BITS+1)'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_BITS'(push_cnt);
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_BITS'(1);
            count_reg <= count_next;
        end
    end

    // handshakes and output beat
    assign in_ready  = count_reg <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign head      = fifo_mem[rd_ptr_reg];

    assign token_kind   = head.kind;
    assign token_value  = head.value;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign last_of_run  = head.last;

    // checks
    a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |-> mode_reg == M_IDLE)
        else $error("halted scanner holds a pending mode");

    a_eoi_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_input) |=> (pos_reg == '0 && !halt_reg && mode_reg == M_IDLE))
        else $error("end of input did not restart the scanner");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_eoi_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_input) |-> push_cnt != 2'd0)
        else $error("end of input produced no token");

endmodule

@@ test/c_subset_lexer_check.sv @@
`timescale 1ns / 1ps
// c_subset_lexer_check: token predictor and scoreboard that watch both lexer channels
module c_subset_lexer_check
    import csl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        end_of_input,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [4:0]  token_kind,
    input  logic [62:0] token_value,
    input  logic [31:0] token_start,
    input  logic [15:0] token_length,
    input  logic        last_of_run,
    output int          error_count,
    output int          tokens_owed
);

    localparam logic [63:0] VALUE_CEIL   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [15:0] LEN_CEIL     = 16'hFFFF;
    localparam int          REPORT_LIMIT = 10;

    // predicted scanner state
    mode_t       scan_mode;
    logic [63:0] accum;
    logic [31:0] tok_start;
    logic [15:0] tok_len;
    logic [31:0] cursor;
    logic [47:0] kw_win;
    logic        in_escape;
    logic        halted;

    // tokens caused by the current input beat, and tokens still to arrive
    result_t beat_tokens[$];
    result_t expected_tokens[$];
    int      mismatches;

    function automatic logic digit_byte(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic word_byte(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDER);
    endfunction

    function automatic logic blank_byte(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] n);
        return (n == LEN_CEIL) ? n : n + 16'd1;
    endfunction

    // one-byte punctuation kind, K_EOF when the byte is none
    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_PLUS:    k = K_PLUS;
            CH_MINUS:   k = K_MINUS;
            CH_STAR:    k = K_STAR;
            CH_SLASH:   k = K_SLASH;
            CH_PERCENT: k = K_PERCENT;
            CH_LT:      k = K_LT;
            CH_GT:      k = K_GT;
            CH_EQ:      k = K_ASSIGN;
            CH_BANG:    k = K_NOT;
            CH_AMP:     k = K_AMP;
            CH_LPAREN:  k = K_LPAREN;
            CH_RPAREN:  k = K_RPAREN;
            CH_LBRACE:  k = K_LBRACE;
            CH_RBRACE:  k = K_RBRACE;
            CH_LBRACK:  k = K_LBRACK;
            CH_RBRACK:  k = K_RBRACK;
            CH_SEMI:    k = K_SEMI;
            CH_COMMA:   k = K_COMMA;
            default:    k = K_EOF;
        endcase
        return k;
    endfunction

    // relational pair kind from the first byte
    function automatic kind_t pair_of(input logic [7:0] c);
        kind_t k;
        if (c == CH_EQ)
            k = K_EQ;
        else if (c == CH_BANG)
            k = K_NE;
        else if (c == CH_LT)
            k = K_LE;
        else
            k = K_GE;
        return k;
    endfunction

    // character literal escape translation
    function automatic logic [7:0] esc_code(input logic [7:0] c);
        logic [7:0] v;
        if (c == CH_LOWER_N)
            v = CH_NL;
        else if (c == CH_LOWER_T)
            v = CH_TAB;
        else if (c == CH_ZERO)
            v = 8'h00;
        else
            v = c;
        return v;
    endfunction

    task automatic push_token(input kind_t kind, input logic [63:0] value,
                              input logic [31:0] start, input logic [15:0] len);
        result_t t;
        if (beat_tokens.size() < 2)
        begin
            t.kind   = kind;
            t.value  = value[62:0];
            t.start  = start;
            t.length = len;
            t.last   = 1'b0;
            beat_tokens.push_back(t);
        end
    endtask

    task automatic clear_scan();
        scan_mode = M_IDLE;
        accum     = '0;
        tok_len   = '0;
        kw_win    = '0;
        in_escape = 1'b0;
    endtask

    // identifier or keyword, matched on length and the last six bytes
    task automatic flush_word();
        kind_t k;
        k = K_IDENT;
        if (tok_len == 16'd3 && kw_win == KW_INT)
            k = K_INT;
        else if (tok_len == 16'd2 && kw_win == KW_IF)
            k = K_IF;
        else if (tok_len == 16'd4 && kw_win == KW_ELSE)
            k = K_ELSE;
        else if (tok_len == 16'd5 && kw_win == KW_WHILE)
            k = K_WHILE;
        else if (tok_len == 16'd6 && kw_win == KW_RETURN)
            k = K_RETURN;
        push_token(k, '0, tok_start, tok_len);
    endtask

    // emit whatever token is open, then go idle
    task automatic flush_token();
        case (scan_mode)
            M_NUM, M_CHR_OPEN, M_CHR_ESC, M_CHR_VAL:
                push_token(K_NUM, accum, tok_start, tok_len);
            M_IDENT:
                flush_word();
            M_STR:
                push_token(K_STR, '0, tok_start, tok_len);
            M_OP:
                push_token(single_kind(accum[7:0]), '0, tok_start, 16'd1);
            M_SLASH:
                push_token(K_SLASH, '0, tok_start, 16'd1);
            default:
                ;
        endcase
        clear_scan();
    endtask

    // byte seen with no token open
    task automatic start_token(input logic [7:0] c, input logic [31:0] pos);
        kind_t k;
        k = single_kind(c);
        if (!blank_byte(c))
        begin
            if (digit_byte(c))
            begin
                scan_mode = M_NUM;
                accum     = {56'd0, c - CH_ZERO};
                tok_start = pos;
                tok_len   = 16'd1;
            end
            else if (word_byte(c))
            begin
                scan_mode = M_IDENT;
                kw_win    = {40'd0, c};
                tok_start = pos;
                tok_len   = 16'd1;
            end
            else if (c == CH_DQUOTE)
            begin
                scan_mode = M_STR;
                tok_start = pos + 32'd1;
                tok_len   = '0;
                in_escape = 1'b0;
            end
            else if (c == CH_SQUOTE)
            begin
                scan_mode = M_CHR_OPEN;
                accum     = '0;
                tok_start = pos;
                tok_len   = 16'd1;
            end
            else if (c == CH_SLASH)
            begin
                scan_mode = M_SLASH;
                tok_start = pos;
            end
            else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT)
            begin
                scan_mode = M_OP;
                accum     = {56'd0, c};
                tok_start = pos;
            end
            else if (k != K_EOF)
                push_token(k, '0, pos, 16'd1);
            else
            begin
                push_token(K_ERR, '0, pos, 16'd1);
                halted = 1'b1;
            end
        end
    endtask

    // advance the predicted scanner by one input beat
    task automatic lex_byte(input logic [7:0] c, input logic eoi);
        logic [31:0] pos;
        logic [63:0] d;
        pos = cursor;
        if (eoi)
        begin
            if (!halted)
                flush_token();
            push_token(K_EOF, '0, pos, 16'd0);
            clear_scan();
            tok_start = '0;
            cursor    = '0;
            halted    = 1'b0;
        end
        else
        begin
            cursor = pos + 32'd1;
            if (!halted)
            begin
                case (scan_mode)
                    M_NUM:
                        if (digit_byte(c))
                        begin
                            d = {56'd0, c - CH_ZERO};
                            if (accum > (VALUE_CEIL - d) / 64'd10)
                                accum = VALUE_CEIL;
                            else
                                accum = accum * 64'd10 + d;
                            tok_len = sat_inc(tok_len);
                        end
                        else
                        begin
                            flush_token();
                            start_token(c, pos);
                        end
                    M_IDENT:
                        if (word_byte(c) || digit_byte(c))
                        begin
                            kw_win  = {kw_win[39:0], c};
                            tok_len = sat_inc(tok_len);
                        end
                        else
                        begin
                            flush_token();
                            start_token(c, pos);
                        end
                    M_STR:
                        if (in_escape)
                        begin
                            in_escape = 1'b0;
                            tok_len   = sat_inc(tok_len);
                        end
                        else if (c == CH_BSLASH)
                        begin
                            in_escape = 1'b1;
                            tok_len   = sat_inc(tok_len);
                        end
                        else if (c == CH_DQUOTE)
                            flush_token();
                        else
                            tok_len = sat_inc(tok_len);
                    M_CHR_OPEN:
                    begin
                        tok_len = sat_inc(tok_len);
                        if (c == CH_BSLASH)
                            scan_mode = M_CHR_ESC;
                        else
                        begin
                            accum     = {56'd0, c};
                            scan_mode = M_CHR_VAL;
                        end
                    end
                    M_CHR_ESC:
                    begin
                        tok_len   = sat_inc(tok_len);
                        accum     = {56'd0, esc_code(c)};
                        scan_mode = M_CHR_VAL;
                    end
                    M_CHR_VAL:
                        if (c == CH_SQUOTE)
                        begin
                            tok_len = sat_inc(tok_len);
                            flush_token();
                        end
                        else
                        begin
                            flush_token();
                            start_token(c, pos);
                        end
                    M_OP:
                        if (c == CH_EQ)
                        begin
                            push_token(pair_of(accum[7:0]), '0, tok_start, 16'd2);
                            clear_scan();
                        end
                        else
                        begin
                            flush_token();
                            start_token(c, pos);
                        end
                    M_SLASH:
                        if (c == CH_SLASH)
                            scan_mode = M_LINE;
                        else if (c == CH_STAR)
                            scan_mode = M_BLOCK;
                        else
                        begin
                            flush_token();
                            start_token(c, pos);
                        end
                    M_LINE:
                        if (c == CH_NL)
                            clear_scan();
                    M_BLOCK:
                        if (c == CH_STAR)
                            scan_mode = M_BLOCK_STAR;
                    M_BLOCK_STAR:
                        if (c == CH_SLASH)
                            clear_scan();
                        else if (c != CH_STAR)
                            scan_mode = M_BLOCK;
                    default:
                    begin
                        clear_scan();
                        start_token(c, pos);
                    end
                endcase
            end
        end
    endtask

    // compare one output beat with the oldest expected token
    task automatic check_token();
        result_t want;
        if (expected_tokens.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected token beat: kind %0d value %0d start %0d length %0d last %0b",
                         token_kind, token_value, token_start, token_length, last_of_run);
        end
        else
        begin
            want = expected_tokens.pop_front();
            if (want.kind !== token_kind || want.value !== token_value ||
                want.start !== token_start || want.length !== token_length ||
                want.last !== last_of_run)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("token mismatch: expected kind %0d value %0d start %0d length %0d last %0b",
                             want.kind, want.value, want.start, want.length, want.last);
                    $display("                got      kind %0d value %0d start %0d length %0d last %0b",
                             token_kind, token_value, token_start, token_length, last_of_run);
                end
            end
        end
    endtask

    // scoreboard: output beats are checked before the input beat of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            tok_start = '0;
            cursor    = '0;
            halted    = 1'b0;
            beat_tokens.delete();
            expected_tokens.delete();
            mismatches = 0;
            error_count <= 0;
            tokens_owed <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_token();
            if (in_valid && in_ready)
            begin
                lex_byte(ch, end_of_input);
                for (int i = 0; i < beat_tokens.size(); i++)
                begin
                    result_t t;
                    t      = beat_tokens[i];
                    t.last = (i == beat_tokens.size() - 1);
                    expected_tokens.push_back(t);
                end
                beat_tokens.delete();
            end
            error_count <= mismatches;
            tokens_owed <= expected_tokens.size();
        end
    end

endmodule

@@ test/c_subset_lexer_test.sv @@
`timescale 1ns / 1ps
// c_subset_lexer_test: clock, reset, source byte stream, output stalls and verdict for the lexer
module c_subset_lexer_test
    import csl_pkg::*;
();

    localparam int RANDOM_BEATS      = 1700;
    localparam int DRAIN_CYCLES      = 20;
    localparam int CYCLE_LIMIT       = 600000;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    typedef struct packed {
        logic [7:0] code;
        logic       stop;
    } src_beat_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  ch           = 8'h00;
    logic        end_of_input = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [4:0]  token_kind;
    logic [62:0] token_value;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;

    int error_count;
    int tokens_owed;

    src_beat_t   source_bytes[$];
    int          beats_done  = 0;
    int          burst_left  = 1;
    int          gap_left    = 0;
    int          cycle_count = 0;
    logic [15:0] ready_pattern = 16'h0000;
    int          pattern_age   = 0;

    c_subset_lexer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_value  (token_value),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    c_subset_lexer_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_value  (token_value),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run),
        .error_count  (error_count),
        .tokens_owed  (tokens_owed)
    );

    always #6 clk = ~clk;

    task automatic put_byte(input logic [7:0] c);
        src_beat_t b;
        b.code = c;
        b.stop = 1'b0;
        source_bytes.push_back(b);
    endtask

    // end of source; the byte lane carries junk
    task automatic put_end();
        src_beat_t b;
        b.code = 8'($urandom);
        b.stop = 1'b1;
        source_bytes.push_back(b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    // identifier character from an index: letters, then digits, then underscore
    function automatic logic [7:0] word_char(input int r);
        logic [7:0] c;
        if (r < 26)
            c = CH_LOWER_A + 8'(r);
        else if (r < 52)
            c = CH_UPPER_A + 8'(r - 26);
        else if (r < 62)
            c = CH_ZERO + 8'(r - 52);
        else
            c = CH_UNDER;
        return c;
    endfunction

    // append one lexeme, mostly well formed, sometimes cut short or illegal
    task automatic add_lexeme();
        int         pick;
        int         n;
        string      s;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            // decimal number, a few long enough to saturate
            n = $urandom_range(0, 19);
            if (n == 0)
            begin
                if ($urandom_range(0, 1) != 0)
                    put_text("9223372036854775807");
                else
                    put_text("9223372036854775808");
            end
            else
            begin
                n = (n < 4) ? $urandom_range(15, 22) : $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        else if (pick < 33)
        begin
            // keywords, near misses and plain names
            case ($urandom_range(0, 4))
                0:       s = "int";
                1:       s = "if";
                2:       s = "else";
                3:       s = "while";
                default: s = "return";
            endcase
            case ($urandom_range(0, 5))
                0, 1:
                    put_text(s);
                2:
                    put_text(s.substr(0, s.len() - 2));
                3:
                begin
                    put_byte(word_char($urandom_range(0, 62)));
                    put_text(s);
                end
                4:
                begin
                    put_text(s);
                    put_byte(word_char($urandom_range(0, 62)));
                end
                default:
                begin
                    put_byte(word_char($urandom_range(0, 52)));
                    n = $urandom_range(0, 7);
                    for (int i = 0; i < n; i++)
                        put_byte(word_char($urandom_range(0, 62)));
                end
            endcase
        end
        else if (pick < 41)
        begin
            // string body with escapes and raw bytes
            put_byte(CH_DQUOTE);
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 7))
                    0:
                        c = 8'($urandom_range(0, 255));
                    1:
                    begin
                        put_byte(CH_BSLASH);
                        c = 8'($urandom_range(0, 255));
                    end
                    default:
                        c = 8'($urandom_range(32, 126));
                endcase
                put_byte(c);
            end
            if ($urandom_range(0, 9) != 0)
                put_byte(CH_DQUOTE);
            else
                put_end();
        end
        else if (pick < 48)
        begin
            // character literal, closing quote sometimes missing
            put_byte(CH_SQUOTE);
            case ($urandom_range(0, 4))
                0:
                begin
                    put_byte(CH_BSLASH);
                    case ($urandom_range(0, 3))
                        0:       put_byte(CH_LOWER_N);
                        1:       put_byte(CH_LOWER_T);
                        2:       put_byte(CH_ZERO);
                        default: put_byte(8'($urandom_range(0, 255)));
                    endcase
                end
                1:
                begin
                    put_end();
                    return;
                end
                default:
                    put_byte(8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 6) != 0)
                put_byte(CH_SQUOTE);
        end
        else if (pick < 57)
        begin
            // relational operator, single or paired with '='
            s = "=!<>";
            put_byte(s[$urandom_range(0, 3)]);
            if ($urandom_range(0, 1))
                put_byte(CH_EQ);
        end
        else if (pick < 69)
        begin
            s = "+-*%()&{}[];,";
            put_byte(s[$urandom_range(0, s.len() - 1)]);
        end
        else if (pick < 72)
            put_byte(CH_SLASH);
        else if (pick < 75)
        begin
            // line comment
            put_byte(CH_SLASH);
            put_byte(CH_SLASH);
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
            begin
                c = 8'($urandom_range(0, 255));
                put_byte((c == CH_NL) ? CH_SPACE : c);
            end
            if ($urandom_range(0, 9) != 0)
                put_byte(CH_NL);
            else
                put_end();
        end
        else if (pick < 78)
        begin
            // block comment, rich in stars and slashes
            put_byte(CH_SLASH);
            put_byte(CH_STAR);
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 3))
                    0:       put_byte(CH_STAR);
                    1:       put_byte(CH_SLASH);
                    default: put_byte(8'($urandom_range(0, 255)));
                endcase
            end
            if ($urandom_range(0, 9) != 0)
            begin
                put_byte(CH_STAR);
                put_byte(CH_SLASH);
            end
            else
                put_end();
        end
        else if (pick < 95)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 5))
                    0:       put_byte(CH_SPACE);
                    1:       put_byte(CH_TAB);
                    2:       put_byte(CH_NL);
                    3:       put_byte(CH_VT);
                    4:       put_byte(CH_FF);
                    default: put_byte(CH_CR);
                endcase
            end
        end
        else if (pick < 96)
        begin
            // illegal byte, halts the scanner until end of source
            s = "#@$`~^|?:.";
            case ($urandom_range(0, 2))
                0:       put_byte(s[$urandom_range(0, s.len() - 1)]);
                1:       put_byte(8'h00);
                default: put_byte(8'($urandom_range(128, 255)));
            endcase
        end
        else
            put_end();
    endtask

    // receiver: rotating ready pattern, reloaded now and then
    always @(posedge clk)
    begin
        if (pattern_age == 0)
        begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = 16'hFFFF;
                1:       ready_pattern = 16'($urandom & $urandom);
                default: ready_pattern = 16'($urandom);
            endcase
            pattern_age = $urandom_range(16, 200);
        end
        else
        begin
            ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
            pattern_age   = pattern_age - 1;
        end
        out_ready <= ready_pattern[0];
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin
        int base;

        // keyword, name, pair, escaped char, slash-star-slash comment, escaped quote
        put_text("int a!='\\n';/*/ */\"\\\"\"");
        put_end();
        // illegal byte halts, the following byte is only counted
        put_text("if(");
        put_byte(8'hFF);
        put_byte(CH_LOWER_A);
        put_end();
        // character literal cut off by end of source
        put_text("'q");
        put_end();

        base = source_bytes.size();
        while (source_bytes.size() < base + RANDOM_BEATS)
            add_lexeme();
        put_end();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        burst_left = $urandom_range(1, 40);

        // sender: bursts of beats separated by random gaps
        while (beats_done < source_bytes.size())
        begin
            @(posedge clk);
            if (in_valid && in_ready)
                beats_done++;
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (beats_done < source_bytes.size())
                begin
                    in_valid     <= 1'b1;
                    ch           <= source_bytes[beats_done].code;
                    end_of_input <= source_bytes[beats_done].stop;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end

        @(posedge clk);
        while (tokens_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && tokens_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
